>>> design/srfc_pkg.sv
// Shared types, constants and the CRC byte step for the sensor response frame checker.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none
package srfc_pkg;

	// Frame layout
	localparam int unsigned FRAME_LEN     = 13;
	localparam int unsigned CRC_LAST      = 10;
	localparam int unsigned PAYLOAD_FIRST = 3;
	localparam int unsigned PAYLOAD_LAST  = 11;
	localparam int unsigned STORE_DEPTH   = PAYLOAD_LAST - PAYLOAD_FIRST + 1;
	localparam int unsigned COUNT_W       = 4;
	localparam int unsigned BYTE_W        = 8;

	// CRC-16, reflected form
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Readings and result widths
	localparam int unsigned NUM_CH  = 4;
	localparam int unsigned RAW_W   = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned RES_W   = 24;
	localparam int unsigned EC_W    = 16;
	localparam int unsigned NUM_CFG = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// Channel order inside a frame record
	localparam int unsigned CH_HUM  = 0;
	localparam int unsigned CH_TEMP = 1;
	localparam int unsigned CH_EC   = 2;
	localparam int unsigned CH_PH   = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EC_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PH_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_OFS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EC_OFS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PH_OFS    = 3'd7;

	localparam logic [CFG_W-1:0] GAIN_RESET = 16'd16384;

	// Defaults for top-level parameters
	localparam int unsigned GAIN_FRACTION_BITS_DEF = 14;
	localparam int unsigned QUEUE_DEPTH_DEF        = 2;

	// One checked frame, handed from the front to the back
	typedef struct packed {
		logic [NUM_CH-1:0][RAW_W-1:0] raw;
		logic                         crc_ok;
	} frame_rec_t;

	// One byte through the reflected CRC, bit at a time
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> design/srfc_if.sv
// Valid/ready channel interfaces for the frame checker: byte input and result output.
// Depends on srfc_pkg for field widths.
`default_nettype none
interface srfc_in_if;
	logic                          valid;
	logic                          ready;
	logic [srfc_pkg::BYTE_W-1:0]   rx_byte;
	logic                          frame_start;

	modport source(output valid, rx_byte, frame_start, input ready);
	modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

interface srfc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [srfc_pkg::RES_W-1:0]  humidity_tenths;
	logic signed [srfc_pkg::RES_W-1:0]  temperature_tenths;
	logic        [srfc_pkg::EC_W-1:0]   ec_value;
	logic signed [srfc_pkg::RES_W-1:0]  acidity_tenths;
	logic                               crc_ok;

	modport source(output valid, humidity_tenths, temperature_tenths, ec_value,
		acidity_tenths, crc_ok, input ready);
	modport sink(input valid, humidity_tenths, temperature_tenths, ec_value,
		acidity_tenths, crc_ok, output ready);
endinterface
`default_nettype wire

>>> design/srfc_front.sv
// Front end: takes frame bytes, tracks position, runs the CRC and builds a frame record.
// Depends on srfc_pkg and srfc_in_if; pushes records into srfc_queue.
`default_nettype none
module srfc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	srfc_in_if.sink               in_ch,
	input  wire logic             full,
	output logic                  push,
	output srfc_pkg::frame_rec_t  push_data
);

	logic [srfc_pkg::COUNT_W-1:0] count_q;
	logic [15:0]                  crc_q;
	logic [srfc_pkg::BYTE_W-1:0]  byte_q [srfc_pkg::STORE_DEPTH];

	logic                         accept;
	logic [srfc_pkg::COUNT_W-1:0] k;
	logic [15:0]                  crc_base;
	logic [15:0]                  rx_crc;

	// A stall only matters on the last byte, but keep it simple and uniform
	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Start flag restarts position and CRC for this very byte
	assign k        = in_ch.frame_start ? '0 : count_q;
	assign crc_base = in_ch.frame_start ? srfc_pkg::CRC_SEED : crc_q;

	// Position and CRC tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= srfc_pkg::CRC_SEED;
		end else if (accept && (k < srfc_pkg::COUNT_W'(srfc_pkg::FRAME_LEN))) begin
			count_q <= k + 1'b1;
			if (k <= srfc_pkg::COUNT_W'(srfc_pkg::CRC_LAST)) begin
				crc_q <= srfc_pkg::crc_feed(crc_base, in_ch.rx_byte);
			end else begin
				crc_q <= crc_base;
			end
		end
	end

	// Payload and CRC low byte, no reset needed
	always_ff @(posedge clk) begin
		if (accept && (k >= srfc_pkg::COUNT_W'(srfc_pkg::PAYLOAD_FIRST))
				&& (k <= srfc_pkg::COUNT_W'(srfc_pkg::PAYLOAD_LAST))) begin
			byte_q[k - srfc_pkg::COUNT_W'(srfc_pkg::PAYLOAD_FIRST)] <= in_ch.rx_byte;
		end
	end

	// Last byte closes the frame
	assign rx_crc = {in_ch.rx_byte, byte_q[8]};
	assign push   = accept && (k == srfc_pkg::COUNT_W'(srfc_pkg::FRAME_LEN - 1));

	always_comb begin
		push_data.raw[srfc_pkg::CH_HUM]  = {byte_q[0], byte_q[1]};
		push_data.raw[srfc_pkg::CH_TEMP] = {byte_q[2], byte_q[3]};
		push_data.raw[srfc_pkg::CH_EC]   = {byte_q[4], byte_q[5]};
		push_data.raw[srfc_pkg::CH_PH]   = {byte_q[6], byte_q[7]};
		push_data.crc_ok                 = (rx_crc == crc_q);
	end

endmodule
`default_nettype wire

>>> design/srfc_queue.sv
// Short queue of frame records between the front and back ends.
// Depends on srfc_pkg for the record type.
`default_nettype none
module srfc_queue #(
	parameter int unsigned DEPTH = srfc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  srfc_pkg::frame_rec_t  push_data,
	input  wire logic             pop,
	output srfc_pkg::frame_rec_t  pop_data,
	output logic                  full,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	srfc_pkg::frame_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/srfc_back.sv
// Back end: calibration registers, gain multiply, rounding, offset, saturation and output.
// Depends on srfc_pkg and srfc_out_if; pops records from srfc_queue.
`default_nettype none
module srfc_back #(
	parameter int unsigned GAIN_FRACTION_BITS = srfc_pkg::GAIN_FRACTION_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [srfc_pkg::CFG_W-1:0]       cfg_data,
	input  srfc_pkg::frame_rec_t                  pop_data,
	input  wire logic                             empty,
	output logic                                  pop,
	srfc_out_if.source                            out_ch
);

	localparam int unsigned PROD_W = 2 * srfc_pkg::RAW_W;
	localparam int unsigned SUM_W  = PROD_W + 2;
	localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (GAIN_FRACTION_BITS - 1);
	localparam logic signed [SUM_W-1:0] S_MAX  = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0] S_MIN  = -SUM_W'(8388608);
	localparam logic signed [SUM_W-1:0] EC_MAX = SUM_W'(65535);

	logic [srfc_pkg::CFG_W-1:0]  cfg_q [srfc_pkg::NUM_CFG];

	logic [PROD_W-1:0]           prod_s1 [srfc_pkg::NUM_CH];
	logic                        ok_s1;
	logic                        valid_s1;

	logic [srfc_pkg::RES_W-1:0]  good_q [srfc_pkg::NUM_CH];
	logic [srfc_pkg::RES_W-1:0]  res_q [srfc_pkg::NUM_CH];
	logic                        ok_q;
	logic                        out_valid_q;

	logic                        load_out;
	logic                        take_s1;
	logic [PROD_W:0]             rnd [srfc_pkg::NUM_CH];
	logic [PROD_W:0]             scaled [srfc_pkg::NUM_CH];
	logic signed [SUM_W-1:0]     ofs [srfc_pkg::NUM_CH];
	logic signed [SUM_W-1:0]     sum [srfc_pkg::NUM_CH];
	logic [srfc_pkg::RES_W-1:0]  sat [srfc_pkg::NUM_CH];

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srfc_pkg::NUM_CFG; i++) begin
				cfg_q[i] <= (i < srfc_pkg::NUM_CH) ? srfc_pkg::GAIN_RESET : '0;
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Flow control between multiply stage and output register
	assign load_out = valid_s1 && (!out_valid_q || out_ch.ready);
	assign take_s1  = !valid_s1 || load_out;
	assign pop      = !empty && take_s1;

	// Stage 1: gain multiply
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < srfc_pkg::NUM_CH; i++) begin
				prod_s1[i] <= PROD_W'(pop_data.raw[i]) * PROD_W'(cfg_q[i]);
			end
			ok_s1 <= pop_data.crc_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= pop;
		end
	end

	// Round, add offset, saturate; conductivity offset is unsigned
	always_comb begin
		for (int i = 0; i < srfc_pkg::NUM_CH; i++) begin
			rnd[i]    = {1'b0, prod_s1[i]} + HALF;
			scaled[i] = rnd[i] >> GAIN_FRACTION_BITS;
			if (i == srfc_pkg::CH_EC) begin
				ofs[i] = SUM_W'(cfg_q[srfc_pkg::CFG_HUM_OFS + srfc_pkg::CFG_IDX_W'(i)]);
			end else begin
				ofs[i] = SUM_W'($signed(cfg_q[srfc_pkg::CFG_HUM_OFS + srfc_pkg::CFG_IDX_W'(i)]));
			end
			sum[i] = $signed({1'b0, scaled[i]}) + ofs[i];
			if (i == srfc_pkg::CH_EC) begin
				if (sum[i] > EC_MAX) begin
					sat[i] = srfc_pkg::RES_W'(16'hFFFF);
				end else if (sum[i] < 0) begin
					sat[i] = '0;
				end else begin
					sat[i] = srfc_pkg::RES_W'(sum[i][srfc_pkg::EC_W-1:0]);
				end
			end else begin
				if (sum[i] > S_MAX) begin
					sat[i] = S_MAX[srfc_pkg::RES_W-1:0];
				end else if (sum[i] < S_MIN) begin
					sat[i] = S_MIN[srfc_pkg::RES_W-1:0];
				end else begin
					sat[i] = sum[i][srfc_pkg::RES_W-1:0];
				end
			end
		end
	end

	// Last good readings; a failed frame repeats them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srfc_pkg::NUM_CH; i++) begin
				good_q[i] <= '0;
			end
		end else if (load_out && ok_s1) begin
			for (int i = 0; i < srfc_pkg::NUM_CH; i++) begin
				good_q[i] <= sat[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < srfc_pkg::NUM_CH; i++) begin
				res_q[i] <= ok_s1 ? sat[i] : good_q[i];
			end
			ok_q <= ok_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.humidity_tenths    = res_q[srfc_pkg::CH_HUM];
	assign out_ch.temperature_tenths = res_q[srfc_pkg::CH_TEMP];
	assign out_ch.ec_value           = res_q[srfc_pkg::CH_EC][srfc_pkg::EC_W-1:0];
	assign out_ch.acidity_tenths     = res_q[srfc_pkg::CH_PH];
	assign out_ch.crc_ok             = ok_q;

endmodule
`default_nettype wire

>>> design/sensor_response_frame_checker_top.sv
// Top level of the sensor response frame checker: front end, record queue, back end.
// Depends on srfc_pkg, srfc_if, srfc_front, srfc_queue and srfc_back.
//
// Usage:
//   in_ch carries one frame byte per item with a frame_start flag on byte 0. A 13-byte
//   frame is checked with the reflected CRC-16 over bytes 0..10 against bytes 11/12.
//   out_ch gives one item per completed frame: four calibrated readings and crc_ok.
//   Bytes past byte 12 and before the next start flag are dropped without a result.
//   The write port (cfg_we, cfg_index, cfg_data) sets gains and offsets; write it only
//   while no frame is in flight.
// Throughput: one byte per cycle while the queue is not full; CRC steps a byte at a time.
// Result path: the record enters the queue on the edge that accepts the last byte, then
//   passes gain multiply, then round/offset/saturate into the output register.
// Stalls: a held out_ch.ready fills the output register, the multiply stage and the
//   QUEUE_DEPTH-entry record queue; in_ch.ready drops only once the queue is full.
// Reset: byte position cleared, CRC to 0xFFFF, gains to 1.0, offsets and last good
//   readings to zero, no item pending.
`default_nettype none
module sensor_response_frame_checker_top #(
	parameter int unsigned GAIN_FRACTION_BITS = srfc_pkg::GAIN_FRACTION_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH        = srfc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	srfc_in_if.sink                               in_ch,
	srfc_out_if.source                            out_ch,
	input  wire logic                             cfg_we,
	input  wire logic [srfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [srfc_pkg::CFG_W-1:0]       cfg_data
);

	srfc_pkg::frame_rec_t push_data;
	srfc_pkg::frame_rec_t pop_data;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;

	// Byte intake and CRC
	srfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue
	srfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	// Calibration and output
	srfc_back #(
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop_data  (pop_data),
		.empty     (empty),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

>>> tb/sv/srfc_reading_monitor.sv
`timescale 1ns / 1ps
// Checker for the sensor response frame checker: watches the byte and result channels and
// the register write port, predicts each calibrated result and compares it field by field.
// Depends on srfc_pkg and srfc_if.
module srfc_reading_monitor #(
	parameter int unsigned FRAC = srfc_pkg::GAIN_FRACTION_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	srfc_in_if                                  in_mon,
	srfc_out_if                                 out_mon,
	input  wire logic                           cfg_we,
	input  wire logic [srfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [srfc_pkg::CFG_W-1:0]     cfg_data,
	output int                                  mismatch_count,
	output int                                  readings_pending
);

	localparam longint RES_MAX = (longint'(1) << (srfc_pkg::RES_W - 1)) - 1;
	localparam longint RES_MIN = -(longint'(1) << (srfc_pkg::RES_W - 1));
	localparam longint EC_MAX  = (longint'(1) << srfc_pkg::EC_W) - 1;

	typedef struct {
		logic signed [srfc_pkg::RES_W-1:0] hum;
		logic signed [srfc_pkg::RES_W-1:0] temp;
		logic        [srfc_pkg::EC_W-1:0]  ec;
		logic signed [srfc_pkg::RES_W-1:0] ph;
		logic                              crc_ok;
	} reading_t;

	// Mirror of the block's state
	logic [srfc_pkg::COUNT_W-1:0] frame_pos;
	logic [15:0]                  crc_acc;
	logic [7:0]                   held [srfc_pkg::PAYLOAD_FIRST:srfc_pkg::FRAME_LEN-1];
	logic [srfc_pkg::CFG_W-1:0]   regs [srfc_pkg::NUM_CFG];
	reading_t                     last_good;
	reading_t                     expected_readings [$];
	int                           errs = 0;

	// Gain with rounding half up, then offset, then clamp to the field range
	function automatic longint calibrate(input logic [15:0] raw, input logic [15:0] gain,
		input longint ofs, input longint lo, input longint hi);
		longint v;
		v = raw;
		v = v * gain;
		v = (v + (longint'(1) << (FRAC - 1))) >> FRAC;
		v = v + ofs;
		if (v < lo)
			v = lo;
		else if (v > hi)
			v = hi;
		return v;
	endfunction

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic [7:0] b;
		logic [15:0] rx_crc;
		reading_t r;
		if (!arst_n) begin
			frame_pos = '0;
			crc_acc = srfc_pkg::CRC_SEED;
			regs[srfc_pkg::CFG_HUM_GAIN]  = srfc_pkg::GAIN_RESET;
			regs[srfc_pkg::CFG_TEMP_GAIN] = srfc_pkg::GAIN_RESET;
			regs[srfc_pkg::CFG_EC_GAIN]   = srfc_pkg::GAIN_RESET;
			regs[srfc_pkg::CFG_PH_GAIN]   = srfc_pkg::GAIN_RESET;
			regs[srfc_pkg::CFG_HUM_OFS]   = '0;
			regs[srfc_pkg::CFG_TEMP_OFS]  = '0;
			regs[srfc_pkg::CFG_EC_OFS]    = '0;
			regs[srfc_pkg::CFG_PH_OFS]    = '0;
			last_good = '{default: '0};
			expected_readings.delete();
			readings_pending <= 0;
		end else begin
			if (cfg_we)
				regs[cfg_index] = cfg_data;

			// Byte accepted: restart on the start flag, CRC over bytes 0..10, keep 3..12
			if (in_mon.valid && in_mon.ready) begin
				b = in_mon.rx_byte;
				if (in_mon.frame_start) begin
					frame_pos = '0;
					crc_acc = srfc_pkg::CRC_SEED;
				end
				if (frame_pos < srfc_pkg::FRAME_LEN) begin
					if (frame_pos <= srfc_pkg::CRC_LAST) begin
						crc_acc = crc_acc ^ {8'h00, b};
						for (int n = 0; n < 8; n++)
							crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ srfc_pkg::CRC_POLY)
								: (crc_acc >> 1);
					end
					if (frame_pos >= srfc_pkg::PAYLOAD_FIRST)
						held[frame_pos] = b;
					// Last byte: low CRC byte came first
					if (frame_pos == srfc_pkg::FRAME_LEN - 1) begin
						rx_crc = {b, held[srfc_pkg::FRAME_LEN-2]};
						if (rx_crc == crc_acc) begin
							last_good.hum = calibrate({held[3], held[4]},
								regs[srfc_pkg::CFG_HUM_GAIN],
								longint'($signed(regs[srfc_pkg::CFG_HUM_OFS])), RES_MIN, RES_MAX);
							last_good.temp = calibrate({held[5], held[6]},
								regs[srfc_pkg::CFG_TEMP_GAIN],
								longint'($signed(regs[srfc_pkg::CFG_TEMP_OFS])), RES_MIN, RES_MAX);
							last_good.ec = calibrate({held[7], held[8]},
								regs[srfc_pkg::CFG_EC_GAIN],
								longint'(regs[srfc_pkg::CFG_EC_OFS]), 0, EC_MAX);
							last_good.ph = calibrate({held[9], held[10]},
								regs[srfc_pkg::CFG_PH_GAIN],
								longint'($signed(regs[srfc_pkg::CFG_PH_OFS])), RES_MIN, RES_MAX);
						end
						r = last_good;
						r.crc_ok = (rx_crc == crc_acc);
						expected_readings.push_back(r);
					end
					frame_pos = frame_pos + 1'b1;
				end
			end

			// Result accepted: compare with the oldest prediction
			if (out_mon.valid && out_mon.ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got hum %0d crc_ok %0b",
						$time, out_mon.humidity_tenths, out_mon.crc_ok);
					errs++;
				end else begin
					r = expected_readings.pop_front();
					check_field("humidity_tenths", r.hum, out_mon.humidity_tenths);
					check_field("temperature_tenths", r.temp, out_mon.temperature_tenths);
					check_field("ec_value", r.ec, out_mon.ec_value);
					check_field("acidity_tenths", r.ph, out_mon.acidity_tenths);
					check_field("crc_ok", r.crc_ok, out_mon.crc_ok);
				end
			end
			readings_pending <= expected_readings.size();
		end
		mismatch_count <= errs;
	end

endmodule

>>> tb/sv/sensor_response_frame_checker_top_tb.sv
`timescale 1ns / 1ps
// Top of the frame checker testbench: clock, reset, frame stimulus, register settings and
// the verdict. Depends on srfc_pkg, srfc_if, the design and srfc_reading_monitor.
module sensor_response_frame_checker_top_tb;

	localparam int PHASES          = 8;
	localparam int QUIET_PHASE     = 3;
	localparam int HOLD_PHASE      = 5;
	localparam int HOLD_CYCLES     = 200;
	localparam int ITEMS_PER_PHASE = 212;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TIMEOUT_NS      = 2_000_000;

	typedef enum logic [2:0] {FR_GOOD, FR_BAD_CRC, FR_SHORT, FR_TRAILING, FR_NOISE} frame_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [srfc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [srfc_pkg::CFG_W-1:0] cfg_data;
	int mismatch_count;
	int readings_pending;
	int items_sent = 0;
	bit tx_quiet = 0;
	bit rx_quiet = 0;
	bit hold_req = 0;

	srfc_in_if  in_ch();
	srfc_out_if out_ch();

	sensor_response_frame_checker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	srfc_reading_monitor monitor (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.readings_pending(readings_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("sensor_response_frame_checker_top_tb NOT OK");
		$finish;
	end

	// Result side: random stalls, a quiet stretch, and one long hold-off
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 0;
			end else begin
				out_ch.ready <= rx_quiet || ($urandom_range(99) >= 27);
			end
		end
	end

	// One byte item, with random idle cycles in front unless quiet
	task automatic send_byte(input logic [7:0] b, input logic start);
		while (!tx_quiet && $urandom_range(99) < 27) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		in_ch.frame_start <= start;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Builds a response frame with a valid CRC, then spoils, cuts or extends it per kind
	task automatic send_frame(input frame_kind_t kind, input bit first_start,
		input bit fixed_raw, input logic [15:0] raw_val);
		logic [7:0] f [srfc_pkg::FRAME_LEN];
		logic [15:0] c;
		logic [15:0] raw;
		int len;
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 8))
				send_byte(8'($urandom), $urandom_range(3) == 0);
		end else begin
			f[0] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h01;
			f[1] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h03;
			f[2] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h08;
			for (int ch = 0; ch < srfc_pkg::NUM_CH; ch++) begin
				if (fixed_raw)
					raw = raw_val;
				else
					case ($urandom_range(5))
						0: raw = 16'h0000;
						1: raw = 16'hFFFF;
						2: raw = 16'h8000;
						default: raw = 16'($urandom);
					endcase
				f[3 + 2 * ch] = raw[15:8];
				f[4 + 2 * ch] = raw[7:0];
			end
			c = srfc_pkg::CRC_SEED;
			for (int n = 0; n <= srfc_pkg::CRC_LAST; n++) begin
				c = c ^ {8'h00, f[n]};
				for (int k = 0; k < 8; k++)
					c = c[0] ? ((c >> 1) ^ srfc_pkg::CRC_POLY) : (c >> 1);
			end
			f[11] = c[7:0];
			f[12] = c[15:8];
			// A single flipped bit anywhere in the frame breaks the CRC
			if (kind == FR_BAD_CRC)
				f[$urandom_range(12)] ^= 8'(1 << $urandom_range(7));
			len = (kind == FR_SHORT) ? $urandom_range(1, 12) : srfc_pkg::FRAME_LEN;
			for (int n = 0; n < len; n++)
				send_byte(f[n], (n == 0) && first_start);
			// Bytes past the end of the frame are dropped by the block
			if (kind == FR_TRAILING)
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom), 1'b0);
		end
	endtask

	task automatic write_reg(input logic [srfc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Gains and offsets for one phase: all-high, all-low, or random
	task automatic load_settings(input int phase);
		logic [15:0] g [4];
		logic [15:0] o [4];
		for (int i = 0; i < 4; i++) begin
			case (phase)
				1: begin
					g[i] = 16'hFFFF;
					o[i] = 16'h7FFF;
				end
				2: begin
					g[i] = 16'h0000;
					o[i] = 16'h8000;
				end
				default: begin
					g[i] = ($urandom_range(2) == 0) ? 16'($urandom)
						: 16'(16384 + $urandom_range(4000) - 2000);
					o[i] = ($urandom_range(1) == 0) ? 16'($urandom)
						: 16'($urandom_range(400) - 200);
				end
			endcase
		end
		// Conductivity offset is unsigned: its extremes are full scale and zero
		if (phase == 1)
			o[2] = 16'hFFFF;
		else if (phase == 2)
			o[2] = 16'h0000;
		write_reg(srfc_pkg::CFG_HUM_GAIN, g[0]);
		write_reg(srfc_pkg::CFG_TEMP_GAIN, g[1]);
		write_reg(srfc_pkg::CFG_EC_GAIN, g[2]);
		write_reg(srfc_pkg::CFG_PH_GAIN, g[3]);
		write_reg(srfc_pkg::CFG_HUM_OFS, o[0]);
		write_reg(srfc_pkg::CFG_TEMP_OFS, o[1]);
		write_reg(srfc_pkg::CFG_EC_OFS, o[2]);
		write_reg(srfc_pkg::CFG_PH_OFS, o[3]);
		cfg_we <= 1'b0;
	endtask

	// Main sequence
	initial begin : stimulus
		int goal;
		frame_kind_t kind;
		int pick;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.rx_byte <= '0;
		in_ch.frame_start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0)
				load_settings(phase);
			tx_quiet = (phase == QUIET_PHASE);
			rx_quiet = (phase == QUIET_PHASE);
			if (phase == HOLD_PHASE)
				hold_req = 1;
			if (phase == 0) begin
				// First frame after reset without a start flag, readings at full scale
				send_frame(FR_GOOD, 1'b0, 1'b1, 16'hFFFF);
				// Zero readings with a broken CRC: last good values come back
				send_frame(FR_BAD_CRC, 1'b1, 1'b1, 16'h0000);
				send_byte(8'($urandom), 1'b0);
			end
			goal = items_sent + ITEMS_PER_PHASE;
			while (items_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 72)
					kind = FR_GOOD;
				else if (pick < 84)
					kind = FR_BAD_CRC;
				else if (pick < 90)
					kind = FR_SHORT;
				else if (pick < 95)
					kind = FR_TRAILING;
				else
					kind = FR_NOISE;
				send_frame(kind, 1'b1, 1'b0, 16'h0000);
			end
			in_ch.valid <= 1'b0;
			// Let every result out and the pipeline empty
			do
				@(posedge clk);
			while (readings_pending != 0);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		if (mismatch_count == 0 && readings_pending == 0)
			$display("sensor_response_frame_checker_top_tb OK");
		else
			$display("sensor_response_frame_checker_top_tb NOT OK");
		$finish;
	end

endmodule
